// ===== design/cpf_pkg.sv =====
// Shared widths, types, register indexes and the CORDIC arctangent table.
`timescale 1ns / 1ps
`default_nettype none
package cpf_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned BiasW    = 20;
  localparam int unsigned WeightW  = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned RateW    = 21;
  localparam int unsigned StepW    = 26;
  localparam int unsigned PitchW   = 26;
  localparam int unsigned AngW     = 27;
  localparam int unsigned CordW    = 35;
  localparam int unsigned ProdW    = 45;
  localparam int unsigned TableLen = 24;
  localparam int unsigned LutIdxW  = 5;
  localparam int unsigned LutW     = 22;
  localparam int unsigned QDepth   = 2;

  // Half a turn, 180 degrees, in Q.16 degrees.
  localparam logic signed [AngW-1:0] HalfTurn = 27'sd11796480;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBlendWeight = 2'd0,
    CfgGyroBias    = 2'd1,
    CfgRateGain    = 2'd2
  } cfg_idx_e;

  // One classified sample as it waits between the front and the back.
  typedef struct packed {
    logic signed [SampleW-1:0] ay;
    logic signed [SampleW-1:0] az;
    logic signed [StepW-1:0]   step;
  } item_t;

  // Arctangent of 2^-i in Q.16 degrees.
  function automatic logic [LutW-1:0] atan_lut(input logic [LutIdxW-1:0] idx);
    logic [LutW-1:0] val;
    case (idx)
      5'd0:    val = 22'd2949120;
      5'd1:    val = 22'd1740967;
      5'd2:    val = 22'd919879;
      5'd3:    val = 22'd466945;
      5'd4:    val = 22'd234379;
      5'd5:    val = 22'd117304;
      5'd6:    val = 22'd58666;
      5'd7:    val = 22'd29335;
      5'd8:    val = 22'd14668;
      5'd9:    val = 22'd7334;
      5'd10:   val = 22'd3667;
      5'd11:   val = 22'd1833;
      5'd12:   val = 22'd917;
      5'd13:   val = 22'd458;
      5'd14:   val = 22'd229;
      5'd15:   val = 22'd115;
      5'd16:   val = 22'd57;
      5'd17:   val = 22'd29;
      5'd18:   val = 22'd14;
      5'd19:   val = 22'd7;
      5'd20:   val = 22'd4;
      5'd21:   val = 22'd2;
      5'd22:   val = 22'd1;
      default: val = 22'd0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

// ===== design/cpf_front.sv =====
// Front end: takes samples, removes the gyro offset and scales the rate to a pitch step.
`timescale 1ns / 1ps
`default_nettype none
module cpf_front (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic signed [cpf_pkg::SampleW-1:0]   accel_y_i,
  input  wire logic signed [cpf_pkg::SampleW-1:0]   accel_z_i,
  input  wire logic signed [cpf_pkg::SampleW-1:0]   gyro_x_i,
  input  wire logic signed [cpf_pkg::BiasW-1:0]     gyro_bias_i,
  input  wire logic        [cpf_pkg::GainW-1:0]     gain_i,
  input  wire logic                                 q_full_i,
  output logic                                      q_push_o,
  output cpf_pkg::item_t                            q_item_o
);

  localparam int unsigned MulW = cpf_pkg::RateW + cpf_pkg::GainW + 1;

  logic                                vld_q, vld_d;
  logic signed [cpf_pkg::SampleW-1:0]  ay_q, az_q;
  logic signed [cpf_pkg::RateW-1:0]    rate_q, rate_d;
  logic signed [MulW-1:0]              prod, prod_rnd;
  logic                                accept;

  assign in_stall_o = vld_q & q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign q_push_o   = vld_q & ~q_full_i;

  // Gyro sample in Q.4 less the Q.4 offset.
  assign rate_d = $signed({gyro_x_i[cpf_pkg::SampleW-1], gyro_x_i, 4'b0000})
                - $signed({gyro_bias_i[cpf_pkg::BiasW-1], gyro_bias_i});

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (q_push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ay_q   <= accel_y_i;
      az_q   <= accel_z_i;
      rate_q <= rate_d;
    end
  end

  // Step in Q.16 degrees, rounded by adding half an LSB before the floor shift.
  assign prod     = rate_q * $signed({1'b0, gain_i});
  assign prod_rnd = prod + MulW'(2048);

  assign q_item_o.ay   = ay_q;
  assign q_item_o.az   = az_q;
  assign q_item_o.step = prod_rnd[MulW-1 -: cpf_pkg::StepW];

endmodule
`default_nettype wire

// ===== design/cpf_queue.sv =====
// Short queue of classified samples between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module cpf_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire cpf_pkg::item_t item_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                avail_o,
  output cpf_pkg::item_t      item_o
);

  localparam int unsigned PtrW = $clog2(cpf_pkg::QDepth);
  localparam int unsigned CntW = $clog2(cpf_pkg::QDepth + 1);

  cpf_pkg::item_t    entry_q [cpf_pkg::QDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(cpf_pkg::QDepth));
  assign avail_o = (cnt_q != '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & avail_o;
  assign item_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/cpf_back.sv =====
// Back end: iterative CORDIC tilt, weighted blend with the pitch state and output register.
`timescale 1ns / 1ps
`default_nettype none
module cpf_back #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                q_avail_i,
  input  wire cpf_pkg::item_t                      q_item_i,
  output logic                                     q_pop_o,
  input  wire logic        [cpf_pkg::WeightW-1:0]  blend_weight_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed      [cpf_pkg::PitchW-1:0]   pitch_estimate_o
);

  localparam int unsigned CordW  = cpf_pkg::CordW;
  localparam int unsigned AngW   = cpf_pkg::AngW;
  localparam int unsigned ProdW  = cpf_pkg::ProdW;
  localparam int unsigned PitchW = cpf_pkg::PitchW;
  localparam int unsigned ShW    = ProdW - 16;
  localparam int unsigned SampW  = cpf_pkg::SampleW;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StRot  = 4'b0010,
    StMul  = 4'b0100,
    StSum  = 4'b1000
  } back_state_e;

  back_state_e                     state_q, state_d;
  logic [cpf_pkg::LutIdxW-1:0]     iter_q, iter_d;
  logic signed [CordW-1:0]         x_q, x_d, y_q, y_d, x_ld, xs, ys;
  logic signed [AngW-1:0]          ang_q, ang_d, lut_ang, accel;
  logic                            zero_q, zero_d;
  logic signed [cpf_pkg::StepW-1:0] step_q, step_d;
  logic signed [ProdW-1:0]         prod_g_q, prod_a_q, acc;
  logic signed [AngW-1:0]          gyro_sum;
  logic        [cpf_pkg::WeightW:0] acc_weight;
  logic signed [ShW-1:0]           p_full;
  logic signed [PitchW-1:0]        p_sat;
  logic signed [PitchW-1:0]        pitch_q, out_q;
  logic                            out_vld_q, out_vld_d;
  logic                            out_load;

  assign q_pop_o = (state_q == StIdle) & q_avail_i;

  // Starting vector; a negative Z turns it by half a turn.
  assign x_ld = $signed({{(CordW - SampW - 16){q_item_i.az[SampW-1]}}, q_item_i.az, 16'h0000});

  assign xs      = x_q >>> iter_q;
  assign ys      = y_q >>> iter_q;
  assign lut_ang = $signed({{(AngW - cpf_pkg::LutW){1'b0}}, cpf_pkg::atan_lut(iter_q)});

  assign accel      = zero_q ? '0 : ang_q;
  assign gyro_sum   = $signed({pitch_q[PitchW-1], pitch_q})
                    + $signed({step_q[cpf_pkg::StepW-1], step_q});
  assign acc_weight = 17'h10000 - {1'b0, blend_weight_i};

  assign acc    = prod_g_q + prod_a_q + ProdW'(32768);
  assign p_full = acc[ProdW-1:16];

  // Saturate the shifted sum to the pitch range.
  always_comb begin
    if (p_full > ShW'($signed({1'b0, {(PitchW-1){1'b1}}}))) begin
      p_sat = {1'b0, {(PitchW-1){1'b1}}};
    end else if (p_full < $signed({{(ShW-PitchW+1){1'b1}}, {(PitchW-1){1'b0}}})) begin
      p_sat = {1'b1, {(PitchW-1){1'b0}}};
    end else begin
      p_sat = p_full[PitchW-1:0];
    end
  end

  assign out_load  = (state_q == StSum) & (~out_vld_q | ~out_stall_i);
  assign out_vld_d = out_load | (out_vld_q & out_stall_i);

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    x_d     = x_q;
    y_d     = y_q;
    ang_d   = ang_q;
    zero_d  = zero_q;
    step_d  = step_q;
    unique case (state_q)
      StIdle: begin
        if (q_pop_o) begin
          state_d = StRot;
          iter_d  = '0;
          step_d  = q_item_i.step;
          zero_d  = (q_item_i.ay == '0) && (q_item_i.az == '0);
          y_d     = $signed({{(CordW - SampW - 16){q_item_i.ay[SampW-1]}},
                             q_item_i.ay, 16'h0000});
          x_d     = x_ld;
          ang_d   = '0;
          if (q_item_i.az[SampW-1]) begin
            x_d   = -x_ld;
            y_d   = -$signed({{(CordW - SampW - 16){q_item_i.ay[SampW-1]}},
                              q_item_i.ay, 16'h0000});
            ang_d = q_item_i.ay[SampW-1] ? -cpf_pkg::HalfTurn : cpf_pkg::HalfTurn;
          end
        end
      end
      StRot: begin
        if (!y_q[CordW-1]) begin
          x_d   = x_q + ys;
          y_d   = y_q - xs;
          ang_d = ang_q + lut_ang;
        end else begin
          x_d   = x_q - ys;
          y_d   = y_q + xs;
          ang_d = ang_q - lut_ang;
        end
        iter_d = iter_q + 1'b1;
        if (iter_q == cpf_pkg::LutIdxW'(CORDIC_STEPS - 1)) begin
          state_d = StMul;
        end
      end
      StMul: begin
        state_d = StSum;
      end
      StSum: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      iter_q    <= '0;
      pitch_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      iter_q    <= iter_d;
      out_vld_q <= out_vld_d;
      if (out_load) begin
        pitch_q <= p_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    ang_q  <= ang_d;
    zero_q <= zero_d;
    step_q <= step_d;
    if (state_q == StMul) begin
      prod_g_q <= ProdW'($signed({1'b0, blend_weight_i}) * gyro_sum);
      prod_a_q <= ProdW'($signed({1'b0, acc_weight}) * accel);
    end
    if (out_load) begin
      out_q <= p_sat;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign pitch_estimate_o = out_q;

endmodule
`default_nettype wire

// ===== design/complementary_pitch_filter.sv =====
// Top level of the complementary pitch filter: configuration registers, front, queue and back.
// With no output stall a result passes the front register, the queue, the CORDIC iterations,
// the multiply and sum states and the output register once its input transaction is accepted.
// The back end works on one sample at a time in its shared CORDIC iteration loop;
// the front and queue take new samples while the back works.
// Reset clears the pitch state to zero and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module complementary_pitch_filter #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic        [cpf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic        [cpf_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [cpf_pkg::SampleW-1:0]  accel_y_i,
  input  wire logic signed [cpf_pkg::SampleW-1:0]  accel_z_i,
  input  wire logic signed [cpf_pkg::SampleW-1:0]  gyro_x_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed      [cpf_pkg::PitchW-1:0]   pitch_estimate_o
);

  logic        [cpf_pkg::WeightW-1:0] blend_weight_q;
  logic signed [cpf_pkg::BiasW-1:0]   gyro_bias_q;
  logic        [cpf_pkg::GainW-1:0]   gain_q;

  logic           q_push, q_full, q_pop, q_avail;
  cpf_pkg::item_t q_wr_item, q_rd_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_weight_q <= 16'd64225;
      gyro_bias_q    <= -20'sd624;
      gain_q         <= 16'd5115;
    end else if (cfg_we_i) begin
      unique case (cpf_pkg::cfg_idx_e'(cfg_idx_i))
        cpf_pkg::CfgBlendWeight: blend_weight_q <= cfg_data_i[cpf_pkg::WeightW-1:0];
        cpf_pkg::CfgGyroBias:    gyro_bias_q    <= $signed(cfg_data_i[cpf_pkg::BiasW-1:0]);
        cpf_pkg::CfgRateGain:    gain_q         <= cfg_data_i[cpf_pkg::GainW-1:0];
        default: begin
        end
      endcase
    end
  end

  cpf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .accel_y_i   (accel_y_i),
    .accel_z_i   (accel_z_i),
    .gyro_x_i    (gyro_x_i),
    .gyro_bias_i (gyro_bias_q),
    .gain_i      (gain_q),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (q_wr_item)
  );

  cpf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_wr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .avail_o (q_avail),
    .item_o  (q_rd_item)
  );

  cpf_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_avail_i        (q_avail),
    .q_item_i         (q_rd_item),
    .q_pop_o          (q_pop),
    .blend_weight_i   (blend_weight_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pitch_estimate_o (pitch_estimate_o)
  );

endmodule
`default_nettype wire

// ===== sim/cpf_checker.sv =====
// Checker for the complementary pitch filter: predicts each pitch update and compares results.
`timescale 1ns / 1ps
module cpf_checker #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic        [cpf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic        [cpf_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                                in_valid_i,
  input  wire logic                                in_stall_i,
  input  wire logic signed [cpf_pkg::SampleW-1:0]  accel_y_i,
  input  wire logic signed [cpf_pkg::SampleW-1:0]  accel_z_i,
  input  wire logic signed [cpf_pkg::SampleW-1:0]  gyro_x_i,
  input  wire logic                                out_valid_i,
  input  wire logic                                out_stall_i,
  input  wire logic signed [cpf_pkg::PitchW-1:0]   pitch_estimate_i,
  output int unsigned                              fail_count_o,
  output int unsigned                              results_o,
  output int unsigned                              pending_o
);
  import cpf_pkg::*;

  localparam longint PitchMax = (longint'(1) <<< (PitchW - 1)) - 1;
  localparam longint PitchMin = -(longint'(1) <<< (PitchW - 1));
  localparam longint HalfTurn = longint'(180) * 65536;
  localparam int unsigned ReportLimit = 10;

  localparam logic        [WeightW-1:0] DefaultWeight = 16'd64225;
  localparam logic signed [BiasW-1:0]   DefaultBias   = -20'sd624;
  localparam logic        [GainW-1:0]   DefaultGain   = 16'd5115;

  logic        [WeightW-1:0] blend_weight;
  logic signed [BiasW-1:0]   gyro_bias;
  logic        [GainW-1:0]   step_gain;
  logic signed [AngW-1:0]    pitch_state;
  logic signed [PitchW-1:0]  pitch_q [$];
  int unsigned               mismatches;
  int unsigned               accepted;

  // Arctangent of 2^-i in Q.16 degrees.
  function automatic longint atan_q16(input int unsigned i);
    case (i)
      0:       return 2949120;
      1:       return 1740967;
      2:       return 919879;
      3:       return 466945;
      4:       return 234379;
      5:       return 117304;
      6:       return 58666;
      7:       return 29335;
      8:       return 14668;
      9:       return 7334;
      10:      return 3667;
      11:      return 1833;
      12:      return 917;
      13:      return 458;
      14:      return 229;
      15:      return 115;
      16:      return 57;
      17:      return 29;
      18:      return 14;
      19:      return 7;
      20:      return 4;
      21:      return 2;
      22:      return 1;
      default: return 0;
    endcase
  endfunction

  // Vectoring CORDIC; a vector in the left half plane is first turned by half a revolution.
  function automatic longint tilt_q16(input longint ay, input longint az);
    longint x, y, xs, ys, ang;
    int unsigned i;
    if (ay == 0 && az == 0) return 0;
    x = az * 65536;
    y = ay * 65536;
    ang = 0;
    if (az < 0) begin
      x = -x;
      y = -y;
      ang = (ay >= 0) ? HalfTurn : -HalfTurn;
    end
    for (i = 0; i < CORDIC_STEPS && i < TableLen; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        ang = ang + atan_q16(i);
      end else begin
        x = x - ys;
        y = y + xs;
        ang = ang - atan_q16(i);
      end
    end
    return ang;
  endfunction

  function automatic longint updated_pitch(input logic signed [SampleW-1:0] ay, az, gx);
    longint rate, step, w, acc, p;
    rate = longint'(gx) * 16 - longint'(gyro_bias);
    step = (rate * longint'(step_gain) + 2048) >>> 12;
    w = longint'(blend_weight);
    acc = w * (longint'(pitch_state) + step) + (65536 - w) * tilt_q16(ay, az) + 32768;
    p = acc >>> 16;
    if (p > PitchMax) p = PitchMax;
    if (p < PitchMin) p = PitchMin;
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic signed [PitchW-1:0] want;
    longint next_p;
    if (!rst_ni) begin
      blend_weight = DefaultWeight;
      gyro_bias    = DefaultBias;
      step_gain    = DefaultGain;
      pitch_state  = '0;
      pitch_q.delete();
      mismatches   = 0;
      accepted     = 0;
      fail_count_o <= 0;
      results_o    <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgBlendWeight: blend_weight = cfg_data_i[WeightW-1:0];
          CfgGyroBias:    gyro_bias    = cfg_data_i;
          CfgRateGain:    step_gain    = cfg_data_i[GainW-1:0];
          default: ;
        endcase
      end
      // The result side is handled first so that a transaction accepted at this edge
      // can never be matched by a result leaving at the same edge.
      if (out_valid_i && !out_stall_i) begin
        accepted++;
        if (pitch_q.size() == 0) begin
          if (mismatches < ReportLimit)
            $display("%0t: pitch result %0d arrived with nothing expected",
                     $time, pitch_estimate_i);
          mismatches++;
        end else begin
          want = pitch_q.pop_front();
          if (want !== pitch_estimate_i) begin
            if (mismatches < ReportLimit)
              $display("%0t: pitch mismatch, expected %0d, got %0d",
                       $time, want, pitch_estimate_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        next_p = updated_pitch(accel_y_i, accel_z_i, gyro_x_i);
        pitch_state = next_p[AngW-1:0];
        pitch_q.push_back(pitch_state[PitchW-1:0]);
      end
      fail_count_o <= mismatches;
      results_o    <= accepted;
      pending_o    <= pitch_q.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the complementary pitch filter: stimulus, result stalls and the verdict.
`timescale 1ns / 1ps
module tb_top;
  import cpf_pkg::*;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned Latency     = CordicSteps + 5;
  localparam int unsigned PhaseCount  = 9;
  localparam int unsigned PhaseItems  = 100;
  localparam int unsigned CycleLimit  = 1000000;
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       cfg_we    = 1'b0;
  logic        [CfgIdxW-1:0]  cfg_idx   = CfgBlendWeight;
  logic        [CfgDataW-1:0] cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  logic signed [SampleW-1:0]  accel_y   = '0;
  logic signed [SampleW-1:0]  accel_z   = '0;
  logic signed [SampleW-1:0]  gyro_x    = '0;
  logic                       out_stall = 1'b0;
  logic                       calm      = 1'b0;
  int unsigned                stall_left   = 0;
  int unsigned                cycles       = 0;
  int unsigned                sent         = 0;
  int unsigned                settings_run = 0;

  logic                       in_stall;
  logic                       out_valid;
  logic signed [PitchW-1:0]   pitch_est;
  int unsigned                fail_count;
  int unsigned                results;
  int unsigned                pending;

  complementary_pitch_filter #(
    .CORDIC_STEPS(CordicSteps)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .accel_y_i       (accel_y),
    .accel_z_i       (accel_z),
    .gyro_x_i        (gyro_x),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .pitch_estimate_o(pitch_est)
  );

  cpf_checker #(
    .CORDIC_STEPS(CordicSteps)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .accel_y_i       (accel_y),
    .accel_z_i       (accel_z),
    .gyro_x_i        (gyro_x),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .pitch_estimate_i(pitch_est),
    .fail_count_o    (fail_count),
    .results_o       (results),
    .pending_o       (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("complementary_pitch_filter regression: fail");
      $finish;
    end
  end

  // Result stalls: mostly short bursts, now and then a long one, none in calm phases.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(3, 39);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic signed [SampleW-1:0] pick_field();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 16'($urandom);
    if (r < 80) return 16'($urandom_range(0, 128) - 64);
    case ($urandom_range(0, 4))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return -16'sd1;
      3:       return 16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  task automatic feed_sample(input logic signed [SampleW-1:0] ay, az, gx);
    int unsigned gap;
    in_valid <= 1'b1;
    accel_y  <= ay;
    accel_z  <= az;
    gyro_x   <= gx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (calm) gap = 0;
    else if ($urandom_range(0, 99) < 55) gap = 0;
    else if ($urandom_range(0, 99) < 80) gap = $urandom_range(1, 3);
    else gap = $urandom_range(4, 40);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender back until every transaction sent so far has produced its result.
  task automatic settle();
    in_valid <= 1'b0;
    while (results < sent) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Upper data bits above the narrow registers carry noise, which the block must drop.
  task automatic program_regs(input logic [WeightW-1:0] w, input logic [BiasW-1:0] b,
                              input logic [GainW-1:0] g);
    logic [3:0] junk;
    junk = 4'($urandom);
    write_reg(CfgBlendWeight, {junk, w});
    write_reg(CfgGyroBias, b);
    junk = 4'($urandom);
    write_reg(CfgRateGain, {junk, g});
    write_reg(CfgSpare, 20'($urandom));
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  initial begin : stimulus
    int unsigned phase, k;
    logic        [WeightW-1:0] w;
    logic        [BiasW-1:0]   b;
    logic        [GainW-1:0]   g;
    logic signed [SampleW-1:0] ay, az, gx;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults from reset: tilt quadrants, the zero vector and field extremes.
    feed_sample(16'sd0, 16'sd0, 16'sd0);
    feed_sample(16'sd1000, 16'sd0, 16'sd100);
    feed_sample(-16'sd1000, 16'sd0, -16'sd100);
    feed_sample(16'sd0, -16'sd1000, 16'sd0);
    feed_sample(16'sd1000, -16'sd1000, 16'sd39);
    feed_sample(-16'sd1000, -16'sd1000, -16'sd39);
    feed_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    feed_sample(16'sh8000, 16'sh8000, 16'sh8000);
    feed_sample(16'sh8000, 16'sh7fff, 16'sd0);
    feed_sample(16'sh7fff, 16'sh8000, 16'sd1);
    feed_sample(16'sd0, 16'sh8000, -16'sd1);
    feed_sample(-16'sd1, -16'sd1, -16'sd1);

    // Accelerometer path only, then the gyro path driven into both rails.
    settle();
    program_regs(16'd0, 20'h80000, 16'hffff);
    feed_sample(16'sh7fff, 16'sd0, 16'sh7fff);
    feed_sample(16'sh8000, -16'sd1, 16'sh8000);
    settle();
    program_regs(16'hffff, 20'h80000, 16'hffff);
    repeat (4) feed_sample(16'sd0, 16'sd1, 16'sh7fff);
    settle();
    program_regs(16'hffff, 20'h7ffff, 16'hffff);
    repeat (5) feed_sample(16'sd0, -16'sd1, 16'sh8000);

    for (phase = 0; phase < PhaseCount; phase++) begin
      settle();
      case (phase)
        0: begin
          w = 16'd64225;
          b = -20'sd624;
          g = 16'd5115;
        end
        1: begin
          w = '0;
          b = '0;
          g = '0;
        end
        2: begin
          w = 16'hffff;
          b = 20'h7ffff;
          g = 16'hffff;
        end
        3: begin
          w = 16'hffff;
          b = 20'h80000;
          g = 16'hffff;
        end
        4: begin
          w = 16'd1;
          b = 20'($urandom);
          g = 16'd1;
        end
        default: begin
          w = 16'($urandom);
          b = 20'($urandom);
          g = 16'($urandom);
        end
      endcase
      program_regs(w, b, g);
      calm <= (phase == 4 || phase == 7);
      for (k = 0; k < PhaseItems; k++) begin
        if (k == PhaseItems / 2) settle();
        ay = pick_field();
        az = pick_field();
        gx = pick_field();
        case ($urandom_range(0, 9))
          0:       ay = '0;
          1:       az = '0;
          default: ;
        endcase
        feed_sample(ay, az, gx);
      end
    end

    settle();
    repeat (Latency + 4) @(posedge clk);
    $display("Checked %0d pitch updates from %0d samples under %0d register settings,",
             results, sent, settings_run);
    $display("covering tilt quadrants, both saturation rails and random gaps on both sides.");
    if (fail_count == 0 && pending == 0) begin
      $display("complementary_pitch_filter regression: pass");
    end else begin
      $display("complementary_pitch_filter regression: fail");
    end
    $finish;
  end

endmodule
